/* hdl/phfp_pkg.sv */
// ============================================================================
// phfp_pkg: shared types and constants of the package header frame parser
// Section state encoding, section and error codes, magic numbers, the
// transaction structs of both channels and the record passed front to back.
// ============================================================================
`default_nettype none

package phfp_pkg;

  // Width of a section byte count: an index region can span 2^36-16 bytes.
  localparam int BL_W         = 37;
  localparam int OUT_OFF_W    = 40;
  localparam int WIDE_OFF_W   = 64;
  localparam int LEAD_LEN     = 96;
  localparam int TYPE_OFFSET  = 78;
  localparam int SIG_TYPE     = 5;
  localparam int PREAMBLE_LEN = 16;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] LEAD_MAGIC [4] = '{8'hED, 8'hAB, 8'hEE, 8'hDB};
  localparam logic [7:0] HDR_MAGIC  [4] = '{8'h8E, 8'hAD, 8'hE8, 8'h01};

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_ENTRY_LIMIT = 1'b0;
  localparam logic REG_DATA_LIMIT  = 1'b1;

  localparam logic [3:0] SEC_LEAD      = 4'd0;
  localparam logic [3:0] SEC_SIG_PRE   = 4'd1;
  localparam logic [3:0] SEC_SIG_IDX   = 4'd2;
  localparam logic [3:0] SEC_SIG_DAT   = 4'd3;
  localparam logic [3:0] SEC_PAD       = 4'd4;
  localparam logic [3:0] SEC_MAIN_PRE  = 4'd5;
  localparam logic [3:0] SEC_MAIN_IDX  = 4'd6;
  localparam logic [3:0] SEC_MAIN_DAT  = 4'd7;
  localparam logic [3:0] SEC_PAYLOAD   = 4'd8;
  localparam logic [3:0] SEC_ERROR     = 4'd9;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_LEAD_MAGIC  = 4'd1;
  localparam logic [3:0] ERR_SIG_TYPE    = 4'd2;
  localparam logic [3:0] ERR_SIG_MAGIC   = 4'd3;
  localparam logic [3:0] ERR_SIG_ENTRIES = 4'd4;
  localparam logic [3:0] ERR_SIG_DATA    = 4'd5;
  localparam logic [3:0] ERR_MAIN_MAGIC  = 4'd6;
  localparam logic [3:0] ERR_MAIN_ENTRIES= 4'd7;
  localparam logic [3:0] ERR_MAIN_DATA   = 4'd8;
  localparam logic [3:0] ERR_TRUNC       = 4'd9;

  typedef enum logic [9:0] {
    S_LEAD     = 10'b00_0000_0001,
    S_SIG_PRE  = 10'b00_0000_0010,
    S_SIG_IDX  = 10'b00_0000_0100,
    S_SIG_DAT  = 10'b00_0000_1000,
    S_PAD      = 10'b00_0001_0000,
    S_MAIN_PRE = 10'b00_0010_0000,
    S_MAIN_IDX = 10'b00_0100_0000,
    S_MAIN_DAT = 10'b00_1000_0000,
    S_PAYLOAD  = 10'b01_0000_0000,
    S_ERROR    = 10'b10_0000_0000
  } sect_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]           byte_out;
    logic [3:0]           section;
    logic [3:0]           error_code;
    logic [OUT_OFF_W-1:0] file_offset;
    logic [OUT_OFF_W-1:0] header_start;
    logic [OUT_OFF_W-1:0] header_end;
    logic                 file_done;
  } out_t;

  // One parsed byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]            data_byte;
    logic [3:0]            section;
    logic [3:0]            sticky_err;
    logic                  at_payload;
    logic                  last_byte;
    logic [WIDE_OFF_W-1:0] pos;
    logic [WIDE_OFF_W-1:0] start;
    logic                  end_load;
    logic [31:0]           entry_count;
    logic [31:0]           data_length;
  } rec_t;

  typedef struct packed {
    sect_state_t     state;
    logic [BL_W-1:0] len;
    logic            set_start;
  } enter_t;

  function automatic logic [3:0] sect_code(input sect_state_t s);
    logic [3:0] c;
    case (s)
      S_LEAD:     c = SEC_LEAD;
      S_SIG_PRE:  c = SEC_SIG_PRE;
      S_SIG_IDX:  c = SEC_SIG_IDX;
      S_SIG_DAT:  c = SEC_SIG_DAT;
      S_PAD:      c = SEC_PAD;
      S_MAIN_PRE: c = SEC_MAIN_PRE;
      S_MAIN_IDX: c = SEC_MAIN_IDX;
      S_MAIN_DAT: c = SEC_MAIN_DAT;
      S_PAYLOAD:  c = SEC_PAYLOAD;
      default:    c = SEC_ERROR;
    endcase
    return c;
  endfunction

  // Enters a section, skipping the ones that turn out to be empty.
  function automatic enter_t enter_section(input sect_state_t first,
                                           input logic [31:0] ec,
                                           input logic [31:0] dl);
    enter_t     r;
    logic [2:0] pad;
    pad = 3'(3'd0 - dl[2:0]);
    r.state = first;
    if (r.state == S_SIG_IDX && ec == '0) r.state = S_SIG_DAT;
    if (r.state == S_SIG_DAT && dl == '0) r.state = S_PAD;
    if (r.state == S_PAD && pad == '0) r.state = S_MAIN_PRE;
    if (r.state == S_MAIN_IDX && ec == '0) r.state = S_MAIN_DAT;
    if (r.state == S_MAIN_DAT && dl == '0) r.state = S_PAYLOAD;
    case (r.state)
      S_SIG_PRE, S_MAIN_PRE: r.len = BL_W'(PREAMBLE_LEN);
      S_SIG_IDX, S_MAIN_IDX: r.len = BL_W'({ec, 4'b0000});
      S_SIG_DAT, S_MAIN_DAT: r.len = BL_W'(dl);
      S_PAD:                 r.len = BL_W'(pad);
      default:               r.len = '0;
    endcase
    r.set_start = (r.state == S_MAIN_PRE);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/package_header_frame_parser.sv */
// ============================================================================
// package_header_frame_parser: section tagging of a package file byte stream
// Tags each byte as lead, signature or main header part, padding or
// payload, checks the framing and reports the main header's extent.
// ============================================================================
// Bytes of one file enter on the in_ channel, one transaction per byte, with
// last_byte set on the final byte. Every byte leaves on the out_ channel as
// one transaction carrying the byte, its section, the error code, its file
// offset and the main header start and end offsets. The block takes one byte
// per cycle while in_stall is low: the classifier handles a byte as it is
// accepted and registers its parse state on the accepting edge. That edge
// also writes the byte's record into the queue, and the output register
// loads the record from the queue once the output is free to take it.
// The classifier and the output stage meet through a two-entry queue; when
// the receiver raises out_stall the output holds, the queue takes bytes until
// both entries are full, and then in_stall rises until the output moves again.
// After the last byte's transaction the parse state returns to the start of
// a new file, while the limit registers keep their values. A synchronous
// reset (rst_n low) clears the parser, the queue and the output valid, and
// sets the entry and data limits to 65536 and 268435456. The user must write
// the limits through the APB port only while no file is in flight; the block
// itself does not enforce this.
// ============================================================================
`default_nettype none

module package_header_frame_parser #(
  parameter int OFFSET_BITS = 40
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // Byte input
  input  wire                 in_valid,
  input  wire phfp_pkg::in_t  in_data,
  output logic                in_stall,
  // Tagged result output
  output logic                out_valid,
  output phfp_pkg::out_t      out_data,
  input  wire                 out_stall,
  // Configuration
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import phfp_pkg::*;

  logic [31:0] entry_limit_r;
  logic [31:0] data_limit_r;
  logic        cfg_write;
  logic        reg_sel;

  logic        q_full;
  logic        q_push;
  rec_t        q_push_data;
  logic        q_pop;
  rec_t        q_head;
  logic        q_not_empty;

  // Register index is address bit 2: entry limit at 0, data limit at 4.
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_sel == REG_DATA_LIMIT) ? data_limit_r : entry_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= 32'd65536;
      data_limit_r  <= 32'd268435456;
    end else if (cfg_write) begin
      if (reg_sel == REG_ENTRY_LIMIT) entry_limit_r <= pwdata;
      else                            data_limit_r  <= pwdata;
    end
  end

  // Front: accepts bytes and classifies them against the framing.
  phfp_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .entry_limit (entry_limit_r),
    .data_limit  (data_limit_r),
    .q_full      (q_full),
    .push        (q_push),
    .push_data   (q_push_data)
  );

  // Queue between classification and result forming.
  phfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  // Back: completes each result and drives the output register.
  phfp_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/phfp_front.sv */
// ============================================================================
// phfp_front: byte classifier of the package header frame parser
// Accepts one byte per cycle unless the queue is full, tracks the section,
// checks magics, signature type and header counts; pushes a record per byte.
// ============================================================================
`default_nettype none

module phfp_front #(
  parameter int OFFSET_BITS = 40
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire phfp_pkg::in_t  in_data,
  output logic                in_stall,
  input  wire  [31:0]         entry_limit,
  input  wire  [31:0]         data_limit,
  input  wire                 q_full,
  output logic                push,
  output phfp_pkg::rec_t      push_data
);
  import phfp_pkg::*;

  sect_state_t            sec_r, sec_nxt;
  logic [BL_W-1:0]        bl_r, bl_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [63:0]            shift_r, shift_nxt;
  logic [31:0]            ec_r, ec_nxt;
  logic [31:0]            dl_r, dl_nxt;
  logic [3:0]             err_r, err_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [7:0]             type_r, type_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [6:0]             lead_idx;
  logic [4:0]             pre_idx;
  logic [BL_W-1:0]        bl_dec;
  logic [63:0]            shift_in;
  logic [31:0]            il, dl_new;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   do_fail, do_enter, end_load, is_main;
  logic [3:0]             fail_code;
  sect_state_t            first;
  logic [31:0]            enter_ec, enter_dl;
  enter_t                 ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    b        = in_data.data_byte;
    lead_idx = 7'(7'(LEAD_LEN) - bl_r[6:0]);
    pre_idx  = 5'(5'(PREAMBLE_LEN) - bl_r[4:0]);
    bl_dec   = (bl_r != '0) ? bl_r - BL_W'(1) : '0;
    shift_in = {shift_r[55:0], b};
    il       = shift_in[63:32];
    dl_new   = shift_in[31:0];
    pos_inc  = (pos_r != {OFFSET_BITS{1'b1}}) ? pos_r + OFFSET_BITS'(1) : pos_r;
    is_main  = (sec_r == S_MAIN_PRE);

    sec_nxt   = sec_r;
    bl_nxt    = bl_r;
    shift_nxt = shift_r;
    ec_nxt    = ec_r;
    dl_nxt    = dl_r;
    err_nxt   = err_r;
    start_nxt = start_r;
    type_nxt  = type_r;
    do_fail   = 1'b0;
    do_enter  = 1'b0;
    end_load  = 1'b0;
    fail_code = ERR_NONE;
    first     = S_PAYLOAD;
    enter_ec  = ec_r;
    enter_dl  = dl_r;

    case (sec_r)
      S_LEAD: begin
        if (lead_idx < 7'd4 && b != LEAD_MAGIC[lead_idx[1:0]]) begin
          do_fail   = 1'b1;
          fail_code = ERR_LEAD_MAGIC;
        end else if (lead_idx == 7'(TYPE_OFFSET + 1) &&
                     {type_r, b} != 16'(SIG_TYPE)) begin
          do_fail   = 1'b1;
          fail_code = ERR_SIG_TYPE;
        end else begin
          if (lead_idx == 7'(TYPE_OFFSET)) type_nxt = b;
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            do_enter = 1'b1;
            first    = S_SIG_PRE;
          end
        end
      end
      S_SIG_PRE, S_MAIN_PRE: begin
        shift_nxt = shift_in;
        if (pre_idx < 5'd4 && b != HDR_MAGIC[pre_idx[1:0]]) begin
          do_fail   = 1'b1;
          fail_code = is_main ? ERR_MAIN_MAGIC : ERR_SIG_MAGIC;
        end else begin
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            if (il > entry_limit) begin
              do_fail   = 1'b1;
              fail_code = is_main ? ERR_MAIN_ENTRIES : ERR_SIG_ENTRIES;
            end else if (dl_new > data_limit) begin
              do_fail   = 1'b1;
              fail_code = is_main ? ERR_MAIN_DATA : ERR_SIG_DATA;
            end else begin
              ec_nxt   = il;
              dl_nxt   = dl_new;
              enter_ec = il;
              enter_dl = dl_new;
              end_load = is_main;
              do_enter = 1'b1;
              first    = is_main ? S_MAIN_IDX : S_SIG_IDX;
            end
          end
        end
      end
      S_SIG_IDX, S_SIG_DAT, S_PAD, S_MAIN_IDX, S_MAIN_DAT: begin
        bl_nxt = bl_dec;
        if (bl_dec == '0) begin
          do_enter = 1'b1;
          case (sec_r)
            S_SIG_IDX:  first = S_SIG_DAT;
            S_SIG_DAT:  first = S_PAD;
            S_PAD:      first = S_MAIN_PRE;
            S_MAIN_IDX: first = S_MAIN_DAT;
            default:    first = S_PAYLOAD;
          endcase
        end
      end
      default: begin
      end
    endcase

    ent = enter_section(first, enter_ec, enter_dl);
    if (do_enter) begin
      sec_nxt = ent.state;
      bl_nxt  = ent.len;
      if (ent.set_start) start_nxt = pos_inc;
    end
    if (do_fail) begin
      err_nxt = fail_code;
      sec_nxt = S_ERROR;
      bl_nxt  = '0;
    end
    pos_nxt = pos_inc;

    push_data.data_byte   = b;
    push_data.section     = sect_code(sec_r);
    push_data.sticky_err  = err_nxt;
    push_data.at_payload  = (sec_nxt == S_PAYLOAD);
    push_data.last_byte   = in_data.last_byte;
    push_data.pos         = WIDE_OFF_W'(pos_r);
    push_data.start       = WIDE_OFF_W'(start_nxt);
    push_data.end_load    = end_load;
    push_data.entry_count = il;
    push_data.data_length = dl_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_byte)) begin
      sec_r   <= S_LEAD;
      bl_r    <= BL_W'(LEAD_LEN);
      pos_r   <= '0;
      shift_r <= '0;
      ec_r    <= '0;
      dl_r    <= '0;
      err_r   <= ERR_NONE;
      start_r <= '0;
      type_r  <= '0;
    end else if (accept) begin
      sec_r   <= sec_nxt;
      bl_r    <= bl_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      ec_r    <= ec_nxt;
      dl_r    <= dl_nxt;
      err_r   <= err_nxt;
      start_r <= start_nxt;
      type_r  <= type_nxt;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_byte |=> sec_r == S_LEAD && pos_r == '0)
    else $error("parse state not restarted after the last byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r == S_ERROR |-> err_r != ERR_NONE)
    else $error("error section without an error code");

endmodule

`default_nettype wire

/* hdl/phfp_queue.sv */
// ============================================================================
// phfp_queue: short record queue between front and back
// A two-entry FIFO that lets the classifier keep taking bytes while a
// finished result waits at the output.
// ============================================================================
`default_nettype none

module phfp_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire phfp_pkg::rec_t  push_data,
  output logic                 full,
  input  wire                  pop,
  output phfp_pkg::rec_t       head,
  output logic                 not_empty
);
  import phfp_pkg::*;

  rec_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= Q_PTR_W'(wr_ptr_r + Q_PTR_W'(1));
      if (pop)  rd_ptr_r <= Q_PTR_W'(rd_ptr_r + Q_PTR_W'(1));
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("record popped from an empty queue");

endmodule

`default_nettype wire

/* hdl/phfp_back.sv */
// ============================================================================
// phfp_back: result stage of the package header frame parser
// Pops records, works out the header end and the final error code, and
// holds each result in the output register until it is taken.
// ============================================================================
`default_nettype none

module phfp_back #(
  parameter int OFFSET_BITS = 40
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire phfp_pkg::rec_t  head,
  input  wire                  not_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output phfp_pkg::out_t       out_data
);
  import phfp_pkg::*;

  localparam int SUM_W = ((OFFSET_BITS > BL_W) ? OFFSET_BITS : BL_W) + 2;

  logic                   out_valid_r;
  out_t                   out_r, out_nxt;
  logic [OFFSET_BITS-1:0] end_r, end_nxt;
  logic [OFFSET_BITS-1:0] end_val, end_sat;
  logic [SUM_W-1:0]       sum;
  logic [63:0]            end_wide;
  logic [3:0]             code;
  logic                   load;

  assign load      = not_empty && (!out_valid_r || !out_stall);
  assign pop       = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    // Main header end: preamble start + 16 + entries * 16 + data, saturating.
    sum = SUM_W'(head.start[OFFSET_BITS-1:0]) + SUM_W'(PREAMBLE_LEN)
        + SUM_W'({head.entry_count, 4'b0000}) + SUM_W'(head.data_length);
    end_sat  = (sum > SUM_W'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}}
                                                   : sum[OFFSET_BITS-1:0];
    end_val  = head.end_load ? end_sat : end_r;
    end_nxt  = head.last_byte ? '0 : end_val;
    end_wide = 64'(end_val);

    code = head.sticky_err;
    if (head.last_byte && head.sticky_err == ERR_NONE && !head.at_payload) begin
      code = ERR_TRUNC;
    end

    out_nxt.byte_out     = head.data_byte;
    out_nxt.section      = head.section;
    out_nxt.error_code   = code;
    out_nxt.file_offset  = head.pos[OUT_OFF_W-1:0];
    out_nxt.header_start = head.start[OUT_OFF_W-1:0];
    out_nxt.header_end   = end_wide[OUT_OFF_W-1:0];
    out_nxt.file_done    = head.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      end_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        end_r       <= end_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  a_end_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load && head.last_byte |=> end_r == '0)
    else $error("header end not cleared after the last byte");

endmodule

`default_nettype wire
